@@ sv/slr_pkg.sv @@
// Shared constants, types and widths for the shuffled Lehmer generator.
`default_nettype none

package slr_pkg;

  // Generator value width and the minimal-standard constants
  localparam int unsigned VAL_W = 31;
  localparam logic [VAL_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

  // Shared multiplier: a 31-bit value times an 18-bit constant
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W = VAL_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] LCG_MUL = 18'd16807;

  // Slot selection by reciprocal multiply: quotient sits above RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned SLOT_Q_W = PROD_W - RECIP_SHIFT;
  localparam int unsigned QD_W = 40;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_TABLE_DEPTH = 32;
  localparam int unsigned DEF_WARMUP_STEPS = 8;

  typedef struct packed {
    logic               en;
    logic [VAL_W-1:0]   a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

@@ sv/slr_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface slr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [slr_pkg::VAL_W-1:0] seed_value;

  modport source (output valid, output req_type, output seed_value, input ready);
  modport sink (input valid, input req_type, input seed_value, output ready);
endinterface

interface slr_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [slr_pkg::VAL_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

@@ sv/slr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/slr_mul_unit.sv @@
// Shared multiplier with registered product and modulo 2^31-1 reduction.
`default_nettype none

module slr_mul_unit (
  input  wire logic                         clk,
  input  wire slr_pkg::mul_req_t            req,
  output logic [slr_pkg::PROD_W-1:0]        prod,
  output logic [slr_pkg::VAL_W-1:0]         red
);

  localparam int unsigned SUM_W = slr_pkg::VAL_W + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] mod_w;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= slr_pkg::PROD_W'(req.a) * slr_pkg::PROD_W'(req.b);
    end
  end

  // 2^31 == 1 mod (2^31-1): fold the high part onto the low part, one correction
  always_comb begin
    mod_w = {1'b0, slr_pkg::LCG_MOD};
    sum = {1'b0, prod[slr_pkg::VAL_W-1:0]}
        + SUM_W'(prod[slr_pkg::PROD_W-1:slr_pkg::VAL_W]);
    if (sum >= mod_w) begin
      red = slr_pkg::VAL_W'(sum - mod_w);
    end else begin
      red = slr_pkg::VAL_W'(sum);
    end
  end

endmodule

`default_nettype wire

@@ sv/shuffled_lehmer_random.sv @@
// Top level: minimal-standard Lehmer generator behind a shuffle table.
// Draw: DRAW_MUL/RED, SLOT_MUL/FIX, TBL_RD, then TBL_WB once the output is free; a new
// request is taken only back in IDLE. Seeding (reseed, or first draw after reset) first
// runs TABLE_DEPTH+WARMUP_STEPS steps, each a MUL and a RED state on the shared multiplier.
// Reset sets the generator to 1 and the index to 0 (table unfilled); the table RAM
// holds garbage until the first seeding fills it, so no clearing pass is run.
`default_nettype none

module shuffled_lehmer_random #(
  parameter int unsigned TABLE_DEPTH  = slr_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned WARMUP_STEPS = slr_pkg::DEF_WARMUP_STEPS
) (
  input  wire logic clk,
  input  wire logic rst,
  slr_req_if.sink   req,
  slr_rsp_if.source rsp
);

  localparam int unsigned VAL_W = slr_pkg::VAL_W;
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned STEPS = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CW    = $clog2(STEPS + 1);
  localparam int unsigned QW    = slr_pkg::SLOT_Q_W;
  localparam int unsigned QD_W  = slr_pkg::QD_W;

  // Slot width and its reciprocal, worked out at elaboration
  localparam longint unsigned SLOT_DIV =
    64'd1 + (64'(slr_pkg::LCG_MOD) - 64'd1) / TABLE_DEPTH;
  localparam longint unsigned SLOT_RECIP = (64'd1 << slr_pkg::RECIP_SHIFT) / SLOT_DIV;
  localparam logic [QD_W-1:0] SLOT_DIV_W = QD_W'(SLOT_DIV);
  localparam logic [slr_pkg::MUL_B_W-1:0] SLOT_RECIP_W = slr_pkg::MUL_B_W'(SLOT_RECIP);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_RED,
    S_DRAW_MUL,
    S_DRAW_RED,
    S_SLOT_MUL,
    S_SLOT_FIX,
    S_TBL_RD,
    S_TBL_WB
  } st_t;

  st_t st;

  logic [VAL_W-1:0] lstate;     // generator value
  logic [VAL_W-1:0] idx;        // last output, selects the next slot
  logic [CW-1:0]    cnt;        // seeding steps left, also the fill address
  logic [AW-1:0]    slot;
  logic             out_valid;
  logic [VAL_W-1:0] out_data;

  slr_pkg::mul_req_t        mreq;
  logic [slr_pkg::PROD_W-1:0] mprod;
  logic [VAL_W-1:0]         mred;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;

  logic             fill_slot;
  logic             out_free;
  logic [VAL_W-1:0] seed_fixed;
  logic [QW-1:0]    q;
  logic [QD_W-1:0]  qd;
  logic             bump;
  logic [QW-1:0]    qc;
  logic [AW-1:0]    slot_next;

  slr_mul_unit u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (mprod),
    .red  (mred)
  );

  slr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign req.ready        = (st == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_data;

  // Room in the output register: empty, or being taken this cycle
  assign out_free  = !out_valid || rsp.ready;
  // Fill runs from the last table entry down; warm-up steps write nothing
  assign fill_slot = (cnt < CW'(TABLE_DEPTH));

  // Zero and the modulus itself would lock the generator; take them as 1
  always_comb begin
    if (req.seed_value == '0 || req.seed_value == slr_pkg::LCG_MOD) begin
      seed_fixed = VAL_W'(1);
    end else begin
      seed_fixed = req.seed_value;
    end
  end

  // Drive the shared multiplier: generator step or reciprocal for the slot
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = lstate;
    mreq.b  = slr_pkg::LCG_MUL;
    unique case (st)
      S_SEED_MUL, S_DRAW_MUL: begin
        mreq.en = 1'b1;
      end
      S_SLOT_MUL: begin
        mreq.en = 1'b1;
        mreq.a  = idx;
        mreq.b  = SLOT_RECIP_W;
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  // Quotient from the reciprocal is at most one short; fix it, then clamp
  always_comb begin
    q    = mprod[slr_pkg::RECIP_SHIFT +: QW];
    qd   = QD_W'(q) * SLOT_DIV_W;
    bump = (QD_W'(idx) >= qd + SLOT_DIV_W);
    qc   = q + QW'(bump);
    if (qc >= QW'(TABLE_DEPTH)) begin
      slot_next = AW'(TABLE_DEPTH - 1);
    end else begin
      slot_next = qc[AW-1:0];
    end
  end

  // Table writes: fill during seeding, replace the picked entry on a draw
  always_comb begin
    if (st == S_SEED_RED) begin
      ram_we    = fill_slot;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = mred;
    end else begin
      ram_we    = (st == S_TBL_WB) && out_free;
      ram_waddr = slot;
      ram_wdata = lstate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      lstate    <= VAL_W'(1);
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Present a fresh result, or drop the one taken this cycle
      if (st == S_TBL_WB && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (req.valid) begin
            cnt <= CW'(STEPS - 1);
            if (req.req_type) begin
              lstate <= seed_fixed;
              st     <= S_SEED_MUL;
            end else if (idx == '0) begin
              // Draw before any seeding: seed with 1 first
              lstate <= VAL_W'(1);
              st     <= S_SEED_MUL;
            end else begin
              st <= S_DRAW_MUL;
            end
          end
        end
        S_SEED_MUL: begin
          st <= S_SEED_RED;
        end
        S_SEED_RED: begin
          lstate <= mred;
          if (cnt == '0) begin
            // Last fill step wrote entry 0; it becomes the index
            idx <= mred;
            st  <= S_DRAW_MUL;
          end else begin
            cnt <= cnt - CW'(1);
            st  <= S_SEED_MUL;
          end
        end
        S_DRAW_MUL: begin
          st <= S_DRAW_RED;
        end
        S_DRAW_RED: begin
          lstate <= mred;
          st     <= S_SLOT_MUL;
        end
        S_SLOT_MUL: begin
          st <= S_SLOT_FIX;
        end
        S_SLOT_FIX: begin
          slot <= slot_next;
          st   <= S_TBL_RD;
        end
        S_TBL_RD: begin
          st <= S_TBL_WB;
        end
        S_TBL_WB: begin
          // Hold until the output register is free, then emit and replace
          if (out_free) begin
            idx      <= ram_rdata;
            out_data <= ram_rdata;
            st       <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lstate_range: assert property (@(posedge clk) disable iff (rst)
    lstate != '0 && lstate != slr_pkg::LCG_MOD)
    else $error("generator left the range 1..2^31-2");

  a_idx_seeded: assert property (@(posedge clk) disable iff (rst)
    st == S_DRAW_MUL |-> idx != '0)
    else $error("draw started on an unfilled table");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> st != S_IDLE)
    else $error("accepted transaction did not start work");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    st == S_TBL_RD |-> slot <= AW'(TABLE_DEPTH - 1))
    else $error("slot beyond the table");

  a_emit: assert property (@(posedge clk) disable iff (rst)
    st == S_TBL_WB && out_free |=> rsp.valid && st == S_IDLE)
    else $error("result not presented after write-back");
`endif

endmodule

`default_nettype wire

@@ dv/slr_tb_pkg.sv @@
// Request kinds shared by the stimulus and the result checker.
package slr_tb_pkg;

  typedef enum logic {
    REQ_DRAW   = 1'b0,
    REQ_RESEED = 1'b1
  } req_kind_e;

endpackage

@@ dv/slr_result_check.sv @@
// Watches both channels, predicts each draw and compares it with the block's output.
module slr_result_check #(
  parameter int unsigned TABLE_DEPTH  = slr_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned WARMUP_STEPS = slr_pkg::DEF_WARMUP_STEPS
) (
  input  logic clk,
  input  logic rst,
  slr_req_if   req,
  slr_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   checked
);
  import slr_pkg::*;
  import slr_tb_pkg::*;

  localparam longint unsigned MULT     = 64'd16807;
  localparam longint unsigned MODULUS  = 64'd2147483647;
  localparam longint unsigned SLOT_DIV = 64'd1 + (MODULUS - 64'd1) / 64'(TABLE_DEPTH);
  localparam int unsigned     SLOT_W   = $clog2(TABLE_DEPTH);

  logic [VAL_W-1:0] gen_state;
  logic [VAL_W-1:0] shuffle_idx;
  logic [VAL_W-1:0] shuffle_tbl [TABLE_DEPTH];
  logic [VAL_W-1:0] expected_draws [$];

  function automatic logic [VAL_W-1:0] lehmer_advance(input logic [VAL_W-1:0] x);
    longint unsigned prod;
    prod = MULT * (64'(x) % MODULUS);
    return VAL_W'(prod % MODULUS);
  endfunction

  // Seed the generator, run the warm-up steps, then fill the table from the top down.
  task automatic refill_table(input logic [VAL_W-1:0] seed);
    logic [VAL_W-1:0] s;
    s = seed;
    if (s == '0 || 64'(s) == MODULUS) s = VAL_W'(1);
    gen_state = s;
    for (int j = TABLE_DEPTH + WARMUP_STEPS - 1; j >= 0; j--) begin
      gen_state = lehmer_advance(gen_state);
      if (j < TABLE_DEPTH) shuffle_tbl[j] = gen_state;
    end
    shuffle_idx = shuffle_tbl[0];
  endtask

  task automatic predict_draw(input req_kind_e kind, input logic [VAL_W-1:0] seed,
                              output logic [VAL_W-1:0] value);
    longint unsigned quot;
    logic [SLOT_W-1:0] slot;
    if (kind == REQ_RESEED) refill_table(seed);
    else if (shuffle_idx == '0) refill_table(VAL_W'(1));
    gen_state = lehmer_advance(gen_state);
    quot = 64'(shuffle_idx) / SLOT_DIV;
    if (quot >= 64'(TABLE_DEPTH)) quot = 64'(TABLE_DEPTH) - 64'd1;
    slot = SLOT_W'(quot);
    value = shuffle_tbl[slot];
    shuffle_idx = value;
    shuffle_tbl[slot] = gen_state;
  endtask

  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst) begin
      gen_state = VAL_W'(1);
      shuffle_idx = '0;
      expected_draws.delete();
      fail_count = 0;
      outstanding = 0;
      checked = 0;
    end else begin
      // Check the result before queuing a new request: no request is accepted and answered at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (expected_draws.size() == 0) begin
          $error("random_value with no request pending: actual %0d", rsp.random_value);
          fail_count++;
        end else begin
          want = expected_draws.pop_front();
          checked++;
          if (rsp.random_value !== want) begin
            $error("random_value mismatch: expected %0d, actual %0d", want,
                   rsp.random_value);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_draw(req_kind_e'(req.req_type), req.seed_value, want);
        expected_draws.push_back(want);
      end
      outstanding = expected_draws.size();
    end
  end

endmodule

@@ dv/tb_shuffled_lehmer_random.sv @@
// Top of the shuffled Lehmer generator testbench: clock, reset, stimulus and verdict.
module tb_shuffled_lehmer_random;
  import slr_pkg::*;
  import slr_tb_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_ITEMS      = 40;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned NUM_PHASES      = 4;
  // Worst case is roughly 2100 requests, all of them reseeds, plus stalls; allow many times that.
  localparam longint unsigned CYCLE_LIMIT = 64'd1_000_000;
  localparam logic [VAL_W-1:0] SEED_ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int n_sent = 0;
  int n_reseeds = 0;
  int fail_count;
  int outstanding;
  int checked;
  longint unsigned cycles = 0;

  slr_req_if req_ch ();
  slr_rsp_if rsp_ch ();

  shuffled_lehmer_random u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slr_result_check u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run: a block that never answers would otherwise spin forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("shuffled_lehmer_random verification failed");
      $finish;
    end
  end

  // Result receiver: stall at the current rate, or hold off for a long stretch on request.
  // The hold is counted here so the sender keeps offering transactions meanwhile.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Pick a reseed value: half the time the full 31-bit range, often the corners that fold to 1.
  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return SEED_ALL_ONES;
      2:       return VAL_W'($urandom_range(1, 100));
      3:       return SEED_ALL_ONES - VAL_W'(1);
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Offer one request from a falling edge and return at the falling edge after it is taken.
  // Idle gaps drive random payload with valid low; valid stays high between
  // back-to-back transactions so it is never dropped and raised in the same step.
  task automatic send_item(input req_kind_e kind, input logic [VAL_W-1:0] seed);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= 1'($urandom_range(1));
      req_ch.seed_value <= VAL_W'($urandom());
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (kind == REQ_RESEED) n_reseeds++;
  endtask

  // Mostly draws; reseeds are rare since each one costs about forty generator steps.
  task automatic send_random();
    if ($urandom_range(15) == 0) send_item(REQ_RESEED, pick_seed());
    else send_item(REQ_DRAW, VAL_W'($urandom()));
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int idle_tab [NUM_PHASES];
    int stall_tab [NUM_PHASES];
    idle_tab = '{0, 80, 0, 12};
    stall_tab = '{0, 0, 80, 12};
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_DRAW;
    req_ch.seed_value = '0;

    // Hold reset, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling. The very first request is a draw, so the block
    // must seed itself with 1 before answering; its seed field is ignored.
    send_item(REQ_DRAW, SEED_ALL_ONES);
    send_item(REQ_DRAW, '0);
    send_item(REQ_RESEED, '0);
    send_item(REQ_DRAW, VAL_W'($urandom()));
    send_item(REQ_RESEED, SEED_ALL_ONES);
    send_item(REQ_DRAW, '0);
    send_item(REQ_RESEED, VAL_W'(1));
    send_item(REQ_RESEED, SEED_ALL_ONES - VAL_W'(1));
    send_item(REQ_DRAW, SEED_ALL_ONES);
    send_item(REQ_DRAW, '0);
    send_item(REQ_DRAW, VAL_W'(31'h5555_5555));
    send_item(REQ_RESEED, VAL_W'(31'h5555_5555));
    send_item(REQ_DRAW, VAL_W'(31'h2AAA_AAAA));
    send_item(REQ_RESEED, VAL_W'(31'h2AAA_AAAA));
    send_item(REQ_DRAW, '0);
    send_item(REQ_RESEED, VAL_W'(31'h4000_0000));
    repeat (6) send_item(REQ_DRAW, VAL_W'($urandom()));

    // Pause the sender until the block has returned everything.
    drain_results();

    // Back-pressure: hold the receiver off while the sender keeps pushing,
    // so the block fills and stalls its input.
    hold_requests++;
    repeat (HOLD_ITEMS) send_random();
    drain_results();

    // Random phases, each with its own idle and stall rates.
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      repeat (ITEMS_PER_PHASE) send_random();
      drain_results();
    end

    // Let any stray result surface before the verdict.
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d reseeds, seeds 0 and 2^31-1 among them), %0d draws checked",
             n_sent, n_reseeds, checked);
    $display("Covered free-running, sender-idle, receiver-stall, mixed and long hold-off traffic");
    if (fail_count == 0 && outstanding == 0) begin
      $display("shuffled_lehmer_random verification clean");
    end else begin
      $display("shuffled_lehmer_random verification failed");
    end
    $finish;
  end

endmodule
